[design/tfm_pkg.sv]
// ============================================================================
// tfm_pkg - trapezoid fuzzy membership package
// Widths, codes and state encoding shared by the membership block.
// ============================================================================
package tfm_pkg;

    localparam int CRISP_WIDTH   = 16;
    localparam int FRAC_BITS     = 15;
    localparam int DEG_WIDTH     = FRAC_BITS + 1;
    localparam int CNT_WIDTH     = $clog2(FRAC_BITS);
    localparam int S_TDATA_WIDTH = ((CRISP_WIDTH + DEG_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((DEG_WIDTH + 7) / 8) * 8;
    localparam int ADDR_WIDTH    = 4;

    localparam logic [DEG_WIDTH-1:0] DEG_ONE  = DEG_WIDTH'(1) << FRAC_BITS;
    localparam logic [DEG_WIDTH-1:0] DEG_ZERO = '0;

    typedef enum logic [1:0] {
        ACT_EVAL  = 2'd0,
        ACT_RAISE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_POINT_A = 2'd0,
        REG_POINT_B = 2'd1,
        REG_POINT_C = 2'd2,
        REG_POINT_D = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

[design/trapezoid_fuzzy_membership.sv]
// ============================================================================
// trapezoid_fuzzy_membership - trapezoid fuzzy set membership cell
// Holds one membership degree, updated by evaluate, raise and clear words.
// ============================================================================
// Every input word returns exactly one output word carrying the stored degree
// (Q1.15, 32768 is 1.0) after the word is applied. For an evaluate word that
// lands on a ramp of the trapezoid, the crisp value is classified and the
// divider loaded at the accepting edge, the restoring divider retires one
// quotient bit per cycle until the quotient is complete and writes it as the
// degree, and the DONE state then moves the result into the output register.
// The next word is taken in the cycle after that move. Every other word
// (evaluate off the ramps, raise, clear, nop) is applied at acceptance and
// goes straight to DONE. One word is in work at a time; a new word is taken
// while the previous result still waits in the output register, and the output
// handoff waits only while that register is full and stalled.
// The breakpoints sit in an APB register file at byte addresses 0, 4, 8, 12
// (point_a..point_d, signed 16 bits) and should be written only while idle.
module trapezoid_fuzzy_membership
    import tfm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata: [15:0] crisp_value (signed), [31:16] level (Q1.15)
    input  logic [S_TDATA_WIDTH-1:0] s_axis_tdata,
    // tuser: [1:0] action
    input  logic [1:0]               s_axis_tuser,
    // output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata: [15:0] membership (Q1.15)
    output logic [M_TDATA_WIDTH-1:0] m_axis_tdata,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_WIDTH-1:0]    paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [CRISP_WIDTH-1:0] r_point_a, r_point_b, r_point_c, r_point_d;
    logic                          cfg_we;
    t_reg_index                    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_a <= '0;
            r_point_b <= '0;
            r_point_c <= '0;
            r_point_d <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_POINT_A: r_point_a <= pwdata[CRISP_WIDTH-1:0];
                REG_POINT_B: r_point_b <= pwdata[CRISP_WIDTH-1:0];
                REG_POINT_C: r_point_c <= pwdata[CRISP_WIDTH-1:0];
                REG_POINT_D: r_point_d <= pwdata[CRISP_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back sign-extended to the bus width
    logic signed [CRISP_WIDTH-1:0] rd_point;
    always_comb begin
        case (cfg_idx)
            REG_POINT_A: rd_point = r_point_a;
            REG_POINT_B: rd_point = r_point_b;
            REG_POINT_C: rd_point = r_point_c;
            REG_POINT_D: rd_point = r_point_d;
            default:     rd_point = r_point_a;
        endcase
    end
    assign prdata = 32'(signed'(rd_point));

    // ------------------------------------------------------------------
    // Input word fields
    // ------------------------------------------------------------------
    logic signed [CRISP_WIDTH-1:0] in_x;
    logic        [DEG_WIDTH-1:0]   in_level;
    t_action                       in_action;
    logic                          in_accept;

    assign in_x      = s_axis_tdata[CRISP_WIDTH-1:0];
    assign in_level  = s_axis_tdata[CRISP_WIDTH +: DEG_WIDTH];
    assign in_action = t_action'(s_axis_tuser);
    assign in_accept = s_axis_tvalid & s_axis_tready;

    // ------------------------------------------------------------------
    // Region classification of the crisp value
    // ------------------------------------------------------------------
    logic lt_a, lt_b, le_c, le_d;
    logic left_shoulder, right_shoulder;
    logic on_rise, on_fall;
    logic [DEG_WIDTH-1:0] flat_deg;     // degree when no ramp applies

    assign lt_a = in_x <  r_point_a;
    assign lt_b = in_x <  r_point_b;
    assign le_c = in_x <= r_point_c;
    assign le_d = in_x <= r_point_d;

    assign left_shoulder  = (r_point_a == r_point_b) && (r_point_b != r_point_c) &&
                            (r_point_c != r_point_d);
    assign right_shoulder = (r_point_c == r_point_d) && (r_point_c != r_point_b) &&
                            (r_point_b != r_point_a);

    assign on_rise = !lt_a && lt_b;
    assign on_fall = !lt_a && !lt_b && !le_c && le_d;

    always_comb begin
        if (lt_a)
            flat_deg = left_shoulder ? DEG_ONE : DEG_ZERO;
        else if (le_c)
            flat_deg = DEG_ONE;         // top (rising edge handled by divider)
        else
            flat_deg = right_shoulder ? DEG_ONE : DEG_ZERO;
    end

    // ramp numerator and span; both are nonnegative whenever the ramp is taken,
    // and numerator < span, so they fit CRISP_WIDTH unsigned bits
    logic signed [CRISP_WIDTH:0] diff_num, diff_span;
    logic        [CRISP_WIDTH-1:0] ramp_num, ramp_span;

    always_comb begin
        if (on_rise) begin
            diff_num  = (CRISP_WIDTH+1)'(in_x)      - (CRISP_WIDTH+1)'(r_point_a);
            diff_span = (CRISP_WIDTH+1)'(r_point_b) - (CRISP_WIDTH+1)'(r_point_a);
        end else begin
            diff_num  = (CRISP_WIDTH+1)'(r_point_d) - (CRISP_WIDTH+1)'(in_x);
            diff_span = (CRISP_WIDTH+1)'(r_point_d) - (CRISP_WIDTH+1)'(r_point_c);
        end
    end
    assign ramp_num  = diff_num[CRISP_WIDTH-1:0];
    assign ramp_span = diff_span[CRISP_WIDTH-1:0];

    // raise: saturate the level to 1.0, then keep the larger
    logic [DEG_WIDTH-1:0] sat_level, raise_deg;
    assign sat_level = in_level[DEG_WIDTH-1] ? DEG_ONE : in_level;

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [CRISP_WIDTH-1:0] r_rem, r_span;
    logic [FRAC_BITS-1:0]   r_quot;
    logic [CNT_WIDTH-1:0]   r_cnt;
    logic [CRISP_WIDTH:0]   rem2;
    logic                   step_ge;
    logic [CRISP_WIDTH:0]   rem_sub;
    logic [FRAC_BITS-1:0]   quot_next;

    assign rem2      = {r_rem, 1'b0};
    assign step_ge   = rem2 >= {1'b0, r_span};
    assign rem_sub   = rem2 - {1'b0, r_span};
    assign quot_next = {r_quot[FRAC_BITS-2:0], step_ge};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    logic   r_m_valid;
    logic   [DEG_WIDTH-1:0] r_degree, r_m_data;
    logic   go_div, div_last, out_load;

    assign raise_deg = (sat_level > r_degree) ? sat_level : r_degree;
    assign go_div    = (in_action == ACT_EVAL) && (on_rise || on_fall);
    assign div_last  = (r_cnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept)
                    n_state = go_div ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (div_last)
                    n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_DONE: out_load      = !r_m_valid || m_axis_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_degree  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // degree update
            if (r_state == ST_IDLE && in_accept) begin
                case (in_action)
                    ACT_EVAL:  if (!go_div) r_degree <= flat_deg;
                    ACT_RAISE: r_degree <= raise_deg;
                    ACT_CLEAR: r_degree <= DEG_ZERO;
                    default: begin
                    end
                endcase
            end else if (r_state == ST_DIV && div_last) begin
                r_degree <= DEG_WIDTH'(quot_next);
            end

            // output register
            if (out_load)
                r_m_valid <= 1'b1;
            else if (m_axis_tready)
                r_m_valid <= 1'b0;
        end
    end

    // divider and output payload (no reset needed)
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_accept && go_div) begin
            r_rem  <= ramp_num;
            r_span <= ramp_span;
            r_quot <= '0;
            r_cnt  <= CNT_WIDTH'(FRAC_BITS - 1);
        end else if (r_state == ST_DIV) begin
            r_rem  <= step_ge ? rem_sub[CRISP_WIDTH-1:0] : rem2[CRISP_WIDTH-1:0];
            r_quot <= quot_next;
            r_cnt  <= r_cnt - 1'b1;
        end
        if (out_load)
            r_m_data <= r_degree;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_TDATA_WIDTH'(r_m_data);

endmodule
